// ===== rtl/gcm_pkg.sv =====
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared constants and types for the greedy change maker.
// ----------------------------------------------------------------------------
package gcm_pkg;

   localparam int NUM_COINS       = 4;
   localparam int AMOUNT_WIDTH    = 16;
   localparam int COIN_WIDTH      = 16;
   localparam int COUNT_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int COIN_IDX_WIDTH  = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;

   typedef logic [COIN_WIDTH-1:0]  coin_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam count_type COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam coin_type COIN_RESET [NUM_COINS] = '{
      COIN_WIDTH'(1), COIN_WIDTH'(5), COIN_WIDTH'(10), COIN_WIDTH'(25)
   };

endpackage

// ===== rtl/greedy_change_maker.sv =====
// ----------------------------------------------------------------------------
// greedy_change_maker
// Greedy coin change over four configurable denominations, highest index first.
// ----------------------------------------------------------------------------
// A single restoring divider, shared by all denominations, retires one
// quotient bit per cycle; a denomination of zero skips the divider and
// records a count of zero. The result appears for one cycle on rsp_valid
// and is not held: the receiver must take it then. busy drops in that
// same cycle, so a new start may be given together with the strobe.
// Denominations are written on the csr port, which is always ready; writes
// to an index past the last coin are dropped.
// ----------------------------------------------------------------------------
module greedy_change_maker
   import gcm_pkg::*;
#(
   parameter int AMOUNT_WIDTH = gcm_pkg::AMOUNT_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [AMOUNT_WIDTH-1:0]    req_amount,
   output logic                       rsp_valid,
   output logic [COUNT_WIDTH-1:0]     rsp_count_0,
   output logic [COUNT_WIDTH-1:0]     rsp_count_1,
   output logic [COUNT_WIDTH-1:0]     rsp_count_2,
   output logic [COUNT_WIDTH-1:0]     rsp_count_3,
   output logic                       rsp_cannot_change,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COIN_WIDTH-1:0]      csr_wdata
);

   localparam int BitCntWidth = (AMOUNT_WIDTH > 1) ? $clog2(AMOUNT_WIDTH) : 1;
   localparam logic [BitCntWidth-1:0] BitLast = BitCntWidth'(AMOUNT_WIDTH - 1);
   localparam logic [COIN_IDX_WIDTH-1:0] IdxTop = COIN_IDX_WIDTH'(NUM_COINS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [COIN_IDX_WIDTH-1:0] idx_ff, idx_in;
   logic [BitCntWidth-1:0]    bit_ff, bit_in;
   logic [AMOUNT_WIDTH-1:0]   dq_ff, dq_in;
   coin_type                  part_ff, part_in;
   coin_type                  coin_ff [NUM_COINS];
   count_type                 cnt_ff [NUM_COINS];
   logic                      cnt_we;
   count_type                 cnt_wdata;
   logic                      rsp_valid_ff;
   count_type                 rsp_cnt_ff [NUM_COINS];
   logic                      rsp_fail_ff;

   coin_type                  coin_sel;
   logic [COIN_WIDTH:0]       trial;
   logic                      fits;
   coin_type                  part_new;
   logic [AMOUNT_WIDTH-1:0]   quot_new;

   // shared restoring divider step
   always_comb begin
      coin_sel = coin_ff[idx_ff];
      trial    = {part_ff, dq_ff[AMOUNT_WIDTH-1]};
      fits     = trial >= {1'b0, coin_sel};
      part_new = fits ? COIN_WIDTH'(trial - {1'b0, coin_sel}) : trial[COIN_WIDTH-1:0];
      quot_new = {dq_ff[AMOUNT_WIDTH-2:0], fits};
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      bit_in    = bit_ff;
      dq_in     = dq_ff;
      part_in   = part_ff;
      cnt_we    = 1'b0;
      cnt_wdata = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIV;
               idx_in   = IdxTop;
               bit_in   = '0;
               dq_in    = req_amount;
               part_in  = '0;
            end
         end
         ST_DIV: begin
            if (coin_sel == '0) begin
               cnt_we = 1'b1;
               if (idx_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end else begin
               bit_in  = bit_ff + 1'b1;
               dq_in   = quot_new;
               part_in = part_new;
               if (bit_ff == BitLast) begin
                  cnt_we    = 1'b1;
                  cnt_wdata = (quot_new > AMOUNT_WIDTH'(COUNT_MAX)) ?
                              COUNT_MAX : COUNT_WIDTH'(quot_new);
                  bit_in    = '0;
                  dq_in     = AMOUNT_WIDTH'(part_new);
                  part_in   = '0;
                  if (idx_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_COINS; i++) begin
            coin_ff[i] <= COIN_RESET[i];
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
         if (csr_valid && csr_ready && (csr_index < CSR_INDEX_WIDTH'(NUM_COINS))) begin
            coin_ff[COIN_IDX_WIDTH'(csr_index)] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      bit_ff  <= bit_in;
      dq_ff   <= dq_in;
      part_ff <= part_in;
      if (cnt_we) begin
         cnt_ff[idx_ff] <= cnt_wdata;
      end
      if (state_ff == ST_DONE) begin
         // dq holds the final remainder here
         rsp_fail_ff <= (dq_ff != '0);
         for (int i = 0; i < NUM_COINS; i++) begin
            rsp_cnt_ff[i] <= (dq_ff != '0) ? '0 : cnt_ff[i];
         end
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_count_0       = rsp_cnt_ff[0];
   assign rsp_count_1       = rsp_cnt_ff[1];
   assign rsp_count_2       = rsp_cnt_ff[2];
   assign rsp_count_3       = rsp_cnt_ff[3];
   assign rsp_cannot_change = rsp_fail_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cannot_change) |->
      (rsp_count_0 == '0 && rsp_count_1 == '0 && rsp_count_2 == '0 && rsp_count_3 == '0))
      else $error("failed item carries nonzero counts");

   a_done_strobe : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (rsp_valid && !busy))
      else $error("finished item not delivered");

endmodule
